### sv/mrirc_pkg.sv
// ----------------------------------------------------------------------------
// mrirc_pkg: shared types for the Modbus read-inputs response checker
// Item layouts, status codes, frame constants and the byte-wide CRC-16 step.
// ----------------------------------------------------------------------------
package mrirc_pkg;

  localparam logic [7:0]  FUNC_READ_INPUTS = 8'h02;
  localparam logic [9:0]  MIN_FRAME_LEN    = 10'd5;
  localparam logic [8:0]  POS_SAT          = 9'd511;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  // Configuration register indexes
  localparam logic REG_SLAVE_ADDRESS    = 1'b0;
  localparam logic REG_REQUESTED_INPUTS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LENGTH   = 3'd1,
    ST_ADDRESS  = 3'd2,
    ST_FUNCTION = 3'd3,
    ST_CRC      = 3'd4,
    ST_COUNT    = 3'd5
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [2:0] status;
  } out_item_t;

  // One byte through the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### sv/mrirc_chan_if.sv
// ----------------------------------------------------------------------------
// mrirc_chan_if: valid/ready channel
// Carries one item per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface mrirc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/modbus_read_inputs_response_checker_unit.sv
// ----------------------------------------------------------------------------
// modbus_read_inputs_response_checker_unit: Modbus RTU read-inputs checker
// Checks a read discrete inputs response byte by byte and flags the frame.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries frame bytes in order (mrirc_pkg::in_item_t); end_of_frame marks
//   the last byte. res carries results (mrirc_pkg::out_item_t): a tentative
//   data item (kind 0) for each data byte with its index, and one status item
//   (kind 1) on the final byte. Drop data items unless the status is ok.
//   wr_en / wr_index / wr_data write slave_address (index 0) and
//   requested_inputs (index 1); write them only while the block is idle.
// Throughput:
//   One byte is accepted per cycle while rx.ready is high. The byte-wide CRC
//   step and the checks sit between the rx handshake and the result register;
//   a data or final byte's result goes there, or to the skid register.
// Stall:
//   The result register is backed by a one-item skid register, so one more
//   result can be held while a result waits. rx.ready drops only while the
//   skid register is full, and rises again once res takes an item.
// Reset:
//   rst (synchronous) clears the frame state, sets the CRC to 0xFFFF, sets
//   slave_address and requested_inputs to 1 and empties both result slots.
// ----------------------------------------------------------------------------
module modbus_read_inputs_response_checker_unit #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic          wr_index,
  input  logic [10:0]   wr_data,
  mrirc_chan_if.sink    rx,
  mrirc_chan_if.source  res
);

  // Configuration registers
  logic [7:0]  slave_address;
  logic [10:0] requested_inputs;

  // Frame state
  logic [8:0]  byte_position;
  logic [7:0]  address_seen;
  logic [7:0]  function_seen;
  logic [7:0]  declared_byte_count;
  logic [15:0] crc_accumulator;

  // Result register and skid register
  mrirc_pkg::out_item_t out_item;
  logic                 out_valid;
  mrirc_pkg::out_item_t skid_item;
  logic                 skid_valid;

  mrirc_pkg::in_item_t  in_item;
  logic                 in_fire;
  logic                 out_fire;

  logic [15:0]          crc_next;
  logic [8:0]           byte_position_next;
  logic [9:0]           total_len;
  logic [8:0]           data_offset;
  logic                 is_data;
  logic [9:0]           expected_len;
  logic                 count_bad;
  mrirc_pkg::status_t   frame_status;
  logic                 has_result;
  mrirc_pkg::out_item_t result;

  assign in_item  = rx.payload;
  assign rx.ready = !skid_valid;
  assign in_fire  = rx.valid && rx.ready;
  assign out_fire = out_valid && res.ready;

  assign res.valid   = out_valid;
  assign res.payload = out_item;

  // Per-byte datapath
  always_comb begin
    crc_next           = mrirc_pkg::crc16_byte(crc_accumulator, in_item.rx_byte);
    byte_position_next = (byte_position < mrirc_pkg::POS_SAT) ?
                         byte_position + 9'd1 : mrirc_pkg::POS_SAT;
    total_len          = {1'b0, byte_position_next};
    data_offset        = byte_position - 9'd3;
    // Data bytes sit between the header and the CRC, bounded by the count.
    is_data            = (byte_position >= 9'd3) &&
                         (data_offset < {1'b0, declared_byte_count});
    expected_len       = 10'd5 + {2'b00, declared_byte_count};
    count_bad          = (declared_byte_count == 8'd0) ||
                         ({declared_byte_count, 3'b000} < requested_inputs);

    // A short frame never reaches the header fields, so the stored ones serve.
    if (total_len < mrirc_pkg::MIN_FRAME_LEN) begin
      frame_status = mrirc_pkg::ST_LENGTH;
    end else if (address_seen != slave_address) begin
      frame_status = mrirc_pkg::ST_ADDRESS;
    end else if (function_seen != mrirc_pkg::FUNC_READ_INPUTS) begin
      frame_status = mrirc_pkg::ST_FUNCTION;
    end else if (crc_next != 16'h0000) begin
      frame_status = mrirc_pkg::ST_CRC;
    end else if (count_bad) begin
      frame_status = mrirc_pkg::ST_COUNT;
    end else if (total_len != expected_len || total_len > 10'(MAX_FRAME_BYTES)) begin
      frame_status = mrirc_pkg::ST_LENGTH;
    end else begin
      frame_status = mrirc_pkg::ST_OK;
    end

    has_result = in_item.end_of_frame || is_data;
    if (in_item.end_of_frame) begin
      result.kind       = mrirc_pkg::KIND_STATUS;
      result.data_byte  = 8'h00;
      result.data_index = 8'h00;
      result.status     = frame_status;
    end else begin
      result.kind       = mrirc_pkg::KIND_DATA;
      result.data_byte  = in_item.rx_byte;
      result.data_index = data_offset[7:0];
      result.status     = mrirc_pkg::ST_OK;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address    <= 8'd1;
      requested_inputs <= 11'd1;
    end else if (wr_en) begin
      case (wr_index)
        mrirc_pkg::REG_SLAVE_ADDRESS:    slave_address    <= wr_data[7:0];
        mrirc_pkg::REG_REQUESTED_INPUTS: requested_inputs <= wr_data;
        default: ;
      endcase
    end
  end

  // Frame state: capture the header, advance the CRC, clear at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      address_seen        <= '0;
      function_seen       <= '0;
      declared_byte_count <= '0;
      crc_accumulator     <= mrirc_pkg::CRC_INIT;
    end else if (in_fire) begin
      if (in_item.end_of_frame) begin
        byte_position       <= '0;
        address_seen        <= '0;
        function_seen       <= '0;
        declared_byte_count <= '0;
        crc_accumulator     <= mrirc_pkg::CRC_INIT;
      end else begin
        byte_position   <= byte_position_next;
        crc_accumulator <= crc_next;
        case (byte_position)
          9'd0:    address_seen        <= in_item.rx_byte;
          9'd1:    function_seen       <= in_item.rx_byte;
          9'd2:    declared_byte_count <= in_item.rx_byte;
          default: ;
        endcase
      end
    end
  end

  // Result register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // rx is held off; drain the skid slot once res takes the item
      if (out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_fire && has_result) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_item <= skid_item;
      end
    end else if (in_fire && has_result) begin
      if (!out_valid || out_fire) begin
        out_item <= result;
      end else begin
        skid_item <= result;
      end
    end
  end

  // Assertions
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while result register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !res.ready) |=> (skid_valid && $stable(skid_item)))
    else $error("skid item lost during stall");

  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.end_of_frame) |=>
      (byte_position == 9'd0 && crc_accumulator == mrirc_pkg::CRC_INIT))
    else $error("frame state not cleared after final byte");

  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.kind == mrirc_pkg::KIND_STATUS) |->
      (out_item.data_byte == 8'h00 && out_item.data_index == 8'h00))
    else $error("status item carries data fields");

  a_status_after_eof: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.end_of_frame && !skid_valid && (!out_valid || out_fire)) |=>
      (out_valid && out_item.kind == mrirc_pkg::KIND_STATUS))
    else $error("final byte gave no status item");

endmodule
